// ===== sv/assert_macros.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RMCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define RMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rmct_pkg.sv =====
// Types and constants shared by the centroid tracker modules.
package rmct_pkg;

    localparam int POS_W      = 11;
    localparam int PIX_W      = 8;
    localparam int MASS_W     = 24;
    localparam int WSUM_W     = 35;
    localparam int FDIM_W     = 12;
    localparam int WDIM_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_STEPS  = WSUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [FDIM_W-1:0] FRAME_WIDTH_RST   = 12'd640;
    localparam logic [FDIM_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
    localparam logic [WDIM_W-1:0] WINDOW_WIDTH_RST  = 8'd75;
    localparam logic [WDIM_W-1:0] WINDOW_HEIGHT_RST = 8'd75;
    localparam logic [POS_W-1:0]  WINDOW_TOP_RST    = 11'd300;
    localparam logic [POS_W-1:0]  WINDOW_LEFT_RST   = 11'd175;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_WINDOW_WIDTH  = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_WINDOW_TOP    = 3'd4
    } cfg_addr_t;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_DIV,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic [PIX_W-1:0] diff_pixel;
        logic             start_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic [POS_W-1:0] centroid_col;
        logic [POS_W-1:0] centroid_row;
        logic [POS_W-1:0] new_window_left;
        logic             motion_found;
    } result_t;

    typedef struct packed {
        logic pix_accept;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic end_possible;
        logic out_pending;
    } status_t;

endpackage

// ===== sv/rmct_ctrl.sv =====
// Sequencer for pixel accumulation, centroid division and result hand-off.
`include "assert_macros.svh"

module rmct_ctrl
    import rmct_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output cmd_t    cmd,
    input  status_t st
);

    ctrl_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PIXEL;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_PIXEL: begin
                // hold the last pixel of a frame while the previous result waits
                s_ready        = !(st.out_pending && st.end_possible);
                cmd.pix_accept = s_valid && s_ready;
                if (cmd.pix_accept && st.frame_end) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_PIXEL;
            end
            default: begin
                state_next = ST_PIXEL;
            end
        endcase
    end

    `RMCT_ASSERT(a_fin_slot_free, (state_reg == ST_FIN) |-> !st.out_pending, "result slot busy at finish")
    `RMCT_ASSERT_NEXT(a_end_starts_div, cmd.pix_accept && st.frame_end, state_reg == ST_DIV, "frame end did not start division")

endmodule

// ===== sv/rmct_datapath.sv =====
// Configuration, raster counters, window sums, serial divider and result register.
`include "assert_macros.svh"

module rmct_datapath
    import rmct_pkg::*;
#(
    parameter int MAX_FRAME_DIM  = 2048,
    parameter int MAX_WINDOW_DIM = 255
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  pixel_in_t             s_data,
    output result_t               m_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  cmd_t                  cmd,
    output status_t               st
);

    localparam int FDW = $clog2(MAX_FRAME_DIM + 1);
    localparam int FCW = (FDW > FDIM_W) ? FDW : FDIM_W;
    localparam int WDW = $clog2(MAX_WINDOW_DIM + 1);
    localparam int WCW = (WDW > WDIM_W) ? WDW : WDIM_W;
    localparam int AW  = ((FCW > POS_W) ? FCW : POS_W) + 2;
    localparam int PW  = PIX_W + POS_W;
    localparam logic [FCW-1:0] FMAX = FCW'(MAX_FRAME_DIM);
    localparam logic [WCW-1:0] WMAX = WCW'(MAX_WINDOW_DIM);

    logic [FDIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [WDIM_W-1:0] window_width_reg, window_height_reg;
    logic [POS_W-1:0]  window_top_reg;

    logic [POS_W-1:0]  col_count_reg, col_count_next;
    logic [POS_W-1:0]  row_count_reg, row_count_next;
    logic [MASS_W-1:0] mass_sum_reg, mass_sum_next;
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [POS_W-1:0]  window_left_reg, window_left_next;
    logic [POS_W-1:0]  last_centroid_reg, last_centroid_next;
    logic [WSUM_W-1:0] dvd_reg, dvd_next;
    logic [MASS_W-1:0] dvs_reg, dvs_next;
    logic [MASS_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0]  quot_reg, quot_next;
    result_t           res_reg, res_next;
    logic              out_valid_reg, out_valid_next;

    logic [FCW-1:0]    fw_c, fh_c;
    logic [WCW-1:0]    ww_c, wh_c;
    logic [AW-1:0]     fw_a, fh_a, ww_a, wh_a, top_a;
    logic [POS_W-1:0]  col_e, row_e;
    logic [AW-1:0]     col_a, row_a, cnt_col_a, cnt_row_a, wl_a;
    logic [MASS_W-1:0] mass_b;
    logic [WSUM_W-1:0] wsum_b;
    logic [PW-1:0]     prod;
    logic              in_win, row_end, frame_end;
    logic [MASS_W:0]   rem_sh, rem_sub;
    logic              ge;
    logic              found;
    logic [AW-1:0]     ccol_a, half_a, left_a;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
            window_top_reg    <= WINDOW_TOP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[FDIM_W-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[FDIM_W-1:0];
                CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_wdata[WDIM_W-1:0];
                CFG_WINDOW_HEIGHT: window_height_reg <= cfg_wdata[WDIM_W-1:0];
                CFG_WINDOW_TOP:    window_top_reg    <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame and window geometry
    always_comb begin
        fw_c = FCW'(frame_width_reg);
        if (fw_c == '0) fw_c = FCW'(1);
        else if (fw_c > FMAX) fw_c = FMAX;
        fh_c = FCW'(frame_height_reg);
        if (fh_c == '0) fh_c = FCW'(1);
        else if (fh_c > FMAX) fh_c = FMAX;
        ww_c = WCW'(window_width_reg);
        if (ww_c == '0) ww_c = WCW'(1);
        else if (ww_c > WMAX) ww_c = WMAX;
        wh_c = WCW'(window_height_reg);
        if (wh_c == '0) wh_c = WCW'(1);
        else if (wh_c > WMAX) wh_c = WMAX;
        fw_a = AW'(fw_c);
        fh_a = AW'(fh_c);
        ww_a = AW'(ww_c);
        wh_a = AW'(wh_c);
        if (ww_a > fw_a) ww_a = fw_a;
        if (wh_a > fh_a) wh_a = fh_a;
        top_a = AW'(window_top_reg);
        if (top_a + wh_a > fh_a) top_a = fh_a - wh_a;
    end

    // raster position and window test for the offered pixel
    always_comb begin
        col_e     = s_data.start_of_frame ? '0 : col_count_reg;
        row_e     = s_data.start_of_frame ? '0 : row_count_reg;
        mass_b    = s_data.start_of_frame ? '0 : mass_sum_reg;
        wsum_b    = s_data.start_of_frame ? '0 : wsum_reg;
        col_a     = AW'(col_e);
        row_a     = AW'(row_e);
        cnt_col_a = AW'(col_count_reg);
        cnt_row_a = AW'(row_count_reg);
        wl_a      = AW'(window_left_reg);
        in_win    = (row_a >= top_a) && (row_a < top_a + wh_a)
                 && (col_a >= wl_a) && (col_a < wl_a + ww_a);
        row_end   = col_a >= fw_a - AW'(1);
        frame_end = row_end && (row_a >= fh_a - AW'(1));
        prod      = PW'(s_data.diff_pixel) * PW'(col_e);
    end

    assign st.frame_end    = frame_end;
    assign st.end_possible = ((cnt_col_a >= fw_a - AW'(1)) && (cnt_row_a >= fh_a - AW'(1)))
                          || ((fw_a == AW'(1)) && (fh_a == AW'(1)));
    assign st.out_pending  = out_valid_reg;

    // restoring divider step
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[WSUM_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = rem_sh >= {1'b0, dvs_reg};
    end

    // window re-centring
    always_comb begin
        found  = dvs_reg != '0;
        ccol_a = AW'(quot_reg);
        half_a = ww_a >> 1;
        left_a = (ccol_a >= half_a) ? ccol_a - half_a : '0;
        if (left_a + ww_a > fw_a) left_a = fw_a - ww_a;
    end

    always_comb begin
        col_count_next     = col_count_reg;
        row_count_next     = row_count_reg;
        mass_sum_next      = mass_sum_reg;
        wsum_next          = wsum_reg;
        window_left_next   = window_left_reg;
        last_centroid_next = last_centroid_reg;
        dvd_next           = dvd_reg;
        dvs_next           = dvs_reg;
        rem_next           = rem_reg;
        quot_next          = quot_reg;
        res_next           = res_reg;
        out_valid_next     = out_valid_reg && !m_ready;

        if (cmd.pix_accept) begin
            mass_sum_next = in_win ? mass_b + MASS_W'(s_data.diff_pixel) : mass_b;
            wsum_next     = in_win ? wsum_b + WSUM_W'(prod) : wsum_b;
            if (frame_end) begin
                dvd_next       = wsum_next;
                dvs_next       = mass_sum_next;
                rem_next       = '0;
                quot_next      = '0;
                mass_sum_next  = '0;
                wsum_next      = '0;
                col_count_next = '0;
                row_count_next = '0;
            end else if (row_end) begin
                col_count_next = '0;
                row_count_next = row_e + POS_W'(1);
            end else begin
                col_count_next = col_e + POS_W'(1);
                row_count_next = row_e;
            end
        end

        if (cmd.div_step) begin
            dvd_next  = {dvd_reg[WSUM_W-2:0], 1'b0};
            rem_next  = ge ? rem_sub[MASS_W-1:0] : rem_sh[MASS_W-1:0];
            quot_next = {quot_reg[POS_W-2:0], ge};
        end

        if (cmd.finish) begin
            if (found) begin
                window_left_next   = POS_W'(left_a);
                last_centroid_next = quot_reg;
            end
            res_next.centroid_col    = found ? quot_reg : last_centroid_reg;
            res_next.centroid_row    = POS_W'(top_a + (wh_a >> 1));
            res_next.new_window_left = found ? POS_W'(left_a) : window_left_reg;
            res_next.motion_found    = found;
            out_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg     <= '0;
            row_count_reg     <= '0;
            mass_sum_reg      <= '0;
            wsum_reg          <= '0;
            window_left_reg   <= WINDOW_LEFT_RST;
            last_centroid_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            col_count_reg     <= col_count_next;
            row_count_reg     <= row_count_next;
            mass_sum_reg      <= mass_sum_next;
            wsum_reg          <= wsum_next;
            window_left_reg   <= window_left_next;
            last_centroid_reg <= last_centroid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        res_reg  <= res_next;
    end

    assign m_data  = res_reg;
    assign m_valid = out_valid_reg;

    `RMCT_ASSERT_NEXT(a_finish_sets_valid, cmd.finish, out_valid_reg, "finish did not raise result valid")
    `RMCT_ASSERT_NEXT(a_frame_restart, cmd.pix_accept && frame_end, (mass_sum_reg == '0) && (col_count_reg == '0) && (row_count_reg == '0), "frame state not restarted")

endmodule

// ===== sv/roi_motion_centroid_tracker_unit.sv =====
// Windowed centroid motion tracker: top level.
// Takes one frame-difference pixel per clock in raster order, except while
// s_ready is low, and keeps its own column and row count, restarted by
// start_of_frame or after the last pixel of a frame. Pixels inside the tracking
// window add to a mass sum and a column weighted sum. Only the last pixel of a
// frame stalls the input: it starts a bit-serial restoring divider of 35 steps,
// and s_ready stays low through the divide steps and the re-centring step that
// follows; the result then sits in an output register while the next frame
// streams in. The last pixel of a frame is held off only while the previous
// result has not been taken. With zero window mass the window is kept and
// motion_found is 0.
// Configuration takes effect at once and is meant to be written between frames.
module roi_motion_centroid_tracker_unit
    import rmct_pkg::*;
#(
    parameter int MAX_FRAME_DIM  = 2048,
    parameter int MAX_WINDOW_DIM = 255
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data
);

    cmd_t    cmd;
    status_t st;

    rmct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .st      (st)
    );

    rmct_datapath #(
        .MAX_FRAME_DIM  (MAX_FRAME_DIM),
        .MAX_WINDOW_DIM (MAX_WINDOW_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== verif/roi_motion_centroid_tracker_unit_tb.sv =====
// Self-checking testbench for the windowed centroid motion tracker with its own frame predictor.
module roi_motion_centroid_tracker_unit_tb;
    import rmct_pkg::*;

    localparam int          FRAME_DIM_MAX  = 2048;
    localparam int          WINDOW_DIM_MAX = 255;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          CYCLE_LIMIT    = 800_000;
    localparam int          RANDOM_PIXELS  = 1300;
    localparam int          REPORT_MAX     = 10;

    typedef enum int {
        PAT_ZERO,
        PAT_FULL,
        PAT_SPARSE,
        PAT_NOISE
    } frame_pattern_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    pixel_in_t             s_data;
    logic                  m_valid;
    logic                  m_ready;
    result_t               m_data;

    pixel_in_t   pixel_q[$];
    result_t     centroid_q[$];
    result_t     want;

    int unsigned reg_frame_w, reg_frame_h, reg_win_w, reg_win_h, reg_win_top;
    logic [10:0] pos_col, pos_row, win_left, prev_centroid;
    logic [23:0] mass_acc;
    logic [34:0] wmass_acc;

    bit          px_xfer, res_xfer, calm;
    int unsigned px_wait, res_wait, res_gap;
    int unsigned px_queued, px_sent, res_seen, still_frames, cfg_writes, mism, cycles;

    roi_motion_centroid_tracker_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 31) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic int unsigned sat_dim(int unsigned v, int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic track_pixel(input pixel_in_t px);
        int unsigned     fw, fh, ww, wh, top, half, left, row_tmp;
        longint unsigned quo;
        logic [10:0]     ccol;
        bit              row_end, frame_end, found;
        result_t         r;
        fw = sat_dim(reg_frame_w, FRAME_DIM_MAX);
        fh = sat_dim(reg_frame_h, FRAME_DIM_MAX);
        ww = sat_dim(reg_win_w, WINDOW_DIM_MAX);
        wh = sat_dim(reg_win_h, WINDOW_DIM_MAX);
        if (ww > fw) ww = fw;
        if (wh > fh) wh = fh;
        top = reg_win_top;
        if (top + wh > fh) top = fh - wh;
        if (px.start_of_frame) begin
            pos_col   = '0;
            pos_row   = '0;
            mass_acc  = '0;
            wmass_acc = '0;
        end
        if (pos_row >= top && pos_row < top + wh &&
            pos_col >= win_left && pos_col < win_left + ww) begin
            mass_acc  = mass_acc + MASS_W'(px.diff_pixel);
            wmass_acc = wmass_acc + WSUM_W'(px.diff_pixel) * WSUM_W'(pos_col);
        end
        row_end   = pos_col >= fw - 1;
        frame_end = row_end && pos_row >= fh - 1;
        if (!frame_end) begin
            if (row_end) begin
                pos_col = '0;
                pos_row = pos_row + 11'd1;
            end else begin
                pos_col = pos_col + 11'd1;
            end
            return;
        end
        found = mass_acc != 0;
        half  = ww / 2;
        if (found) begin
            quo  = 64'(wmass_acc) / 64'(mass_acc);
            ccol = quo[10:0];
            left = (ccol >= half) ? ccol - half : 0;
            if (left + ww > fw) left = fw - ww;
            win_left      = left[10:0];
            prev_centroid = ccol;
        end else begin
            ccol = prev_centroid;
        end
        row_tmp           = top + wh / 2;
        r.centroid_col    = ccol;
        r.centroid_row    = row_tmp[10:0];
        r.new_window_left = win_left;
        r.motion_found    = found;
        centroid_q.push_back(r);
        pos_col   = '0;
        pos_row   = '0;
        mass_acc  = '0;
        wmass_acc = '0;
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            px_xfer       <= 1'b0;
            res_xfer      <= 1'b0;
            reg_frame_w   = 32'(FRAME_WIDTH_RST);
            reg_frame_h   = 32'(FRAME_HEIGHT_RST);
            reg_win_w     = 32'(WINDOW_WIDTH_RST);
            reg_win_h     = 32'(WINDOW_HEIGHT_RST);
            reg_win_top   = 32'(WINDOW_TOP_RST);
            win_left      = WINDOW_LEFT_RST;
            prev_centroid = '0;
            pos_col       = '0;
            pos_row       = '0;
            mass_acc      = '0;
            wmass_acc     = '0;
        end else begin
            px_xfer  <= s_valid && s_ready;
            res_xfer <= m_valid && m_ready;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_FRAME_WIDTH:   reg_frame_w = 32'(cfg_wdata[11:0]);
                    CFG_FRAME_HEIGHT:  reg_frame_h = 32'(cfg_wdata[11:0]);
                    CFG_WINDOW_WIDTH:  reg_win_w   = 32'(cfg_wdata[7:0]);
                    CFG_WINDOW_HEIGHT: reg_win_h   = 32'(cfg_wdata[7:0]);
                    CFG_WINDOW_TOP:    reg_win_top = 32'(cfg_wdata[10:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                track_pixel(s_data);
                px_sent++;
            end
            if (m_valid && m_ready) begin
                if (centroid_q.size() == 0) begin
                    mism++;
                    if (mism <= REPORT_MAX)
                        $display("Unexpected result col=%0d row=%0d left=%0d found=%0b",
                                 m_data.centroid_col, m_data.centroid_row,
                                 m_data.new_window_left, m_data.motion_found);
                end else begin
                    want = centroid_q.pop_front();
                    res_seen++;
                    if (!want.motion_found) still_frames++;
                    if (m_data.centroid_col !== want.centroid_col ||
                        m_data.centroid_row !== want.centroid_row ||
                        m_data.new_window_left !== want.new_window_left ||
                        m_data.motion_found !== want.motion_found) begin
                        mism++;
                        if (mism <= REPORT_MAX)
                            $display("Result %0d col/row/left/found exp %0d/%0d/%0d/%0b",
                                     res_seen, want.centroid_col, want.centroid_row,
                                     want.new_window_left, want.motion_found,
                                     " got %0d/%0d/%0d/%0b",
                                     m_data.centroid_col, m_data.centroid_row,
                                     m_data.new_window_left, m_data.motion_found);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            px_wait <= 0;
        end else if (!s_valid || px_xfer) begin
            if (px_wait != 0) begin
                px_wait <= px_wait - 1;
                s_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                s_data  <= pixel_q.pop_front();
                s_valid <= 1'b1;
                px_wait <= draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            res_wait <= 0;
        end else if (res_xfer) begin
            res_gap = draw_gap();
            res_wait <= res_gap;
            m_ready  <= (res_gap == 0);
        end else if (res_wait != 0) begin
            res_wait <= res_wait - 1;
            m_ready  <= (res_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        while (px_sent != px_queued || centroid_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic program_tracker(input int unsigned fw_v, fh_v, ww_v, wh_v, top_v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FRAME_WIDTH;
        cfg_wdata <= CFG_DATA_W'(fw_v);
        @(negedge aclk);
        cfg_addr  <= CFG_FRAME_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(fh_v);
        @(negedge aclk);
        cfg_addr  <= CFG_WINDOW_WIDTH;
        cfg_wdata <= CFG_DATA_W'(ww_v);
        @(negedge aclk);
        cfg_addr  <= CFG_WINDOW_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(wh_v);
        @(negedge aclk);
        cfg_addr  <= CFG_WINDOW_TOP;
        cfg_wdata <= CFG_DATA_W'(top_v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_writes += 5;
        @(posedge aclk);
    endtask

    task automatic push_pixel(input int unsigned pix, input bit sof);
        pixel_in_t px;
        px.diff_pixel     = PIX_W'(pix);
        px.start_of_frame = sof;
        pixel_q.push_back(px);
        px_queued++;
    endtask

    task automatic push_frame(input int unsigned w, h, input frame_pattern_t style,
                              input bit with_sof);
        int unsigned n, pix;
        for (n = 0; n < w * h; n++) begin
            case (style)
                PAT_ZERO:   pix = 0;
                PAT_FULL:   pix = 255;
                PAT_SPARSE: pix = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : 0;
                default:    pix = $urandom_range(0, 255);
            endcase
            push_pixel(pix, with_sof && n == 0);
        end
    endtask

    initial begin : stimulus
        int unsigned   n, lo, fw, fh, ww, wh, top, start_px, rand_px;
        frame_pattern_t style;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // pull the window from its reset position to the left edge
        program_tracker(176, 1, 255, 1, 0);
        for (n = 0; n < 176; n++) push_pixel((n == 175) ? 255 : 0, n == 0);

        // directed: empty window, extremes, restart part way through a frame
        program_tracker(4, 3, 2, 2, 2047);
        push_frame(4, 3, PAT_ZERO, 1'b1);
        push_pixel(255, 1'b1);
        push_pixel(0, 1'b0);
        push_pixel(128, 1'b0);
        push_frame(4, 3, PAT_FULL, 1'b1);

        // zero register values saturate to one, single-pixel frames back to back
        program_tracker(0, 0, 0, 0, 2047);
        push_frame(1, 1, PAT_FULL, 1'b1);
        push_frame(1, 1, PAT_ZERO, 1'b0);
        push_frame(1, 1, PAT_NOISE, 1'b1);

        rand_px = 0;
        while (rand_px < RANDOM_PIXELS) begin
            wait_drained();
            lo = win_left + 1;
            fw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16)
                                              : $urandom_range(lo, lo + 15);
            if (fw > FRAME_DIM_MAX) fw = FRAME_DIM_MAX;
            fh = $urandom_range(1, 6);
            case ($urandom_range(0, 4))
                0:       ww = 0;
                1:       ww = 255;
                2:       ww = $urandom_range(1, 255);
                default: ww = $urandom_range(1, fw > 255 ? 255 : fw);
            endcase
            case ($urandom_range(0, 4))
                0:       wh = 0;
                1:       wh = 255;
                2:       wh = $urandom_range(1, 255);
                default: wh = $urandom_range(1, fh);
            endcase
            case ($urandom_range(0, 4))
                0:       top = 0;
                1:       top = 2047;
                default: top = $urandom_range(0, fh);
            endcase
            program_tracker((fw == 1 && $urandom_range(0, 1)) ? 0 : fw,
                            (fh == 1 && $urandom_range(0, 1)) ? 0 : fh,
                            ($urandom_range(0, 15) << 8) | ww,
                            ($urandom_range(0, 15) << 8) | wh,
                            ($urandom_range(0, 1) << 11) | top);
            start_px = px_queued;
            repeat ($urandom_range(2, 6)) begin
                case ($urandom_range(0, 9))
                    0:       style = PAT_ZERO;
                    1:       style = PAT_FULL;
                    2, 3, 4: style = PAT_SPARSE;
                    default: style = PAT_NOISE;
                endcase
                n = $urandom_range(0, 19);
                if (n < 17) begin
                    push_frame(fw, fh, style, n != 16);
                end else begin
                    repeat ($urandom_range(1, fw * fh))
                        push_pixel($urandom_range(0, 255), $urandom_range(0, 7) == 0);
                end
            end
            rand_px += px_queued - start_px;
        end

        wait_drained();
        $display("Covered %0d pixels and %0d frame results (%0d with no motion)",
                 px_sent, res_seen, still_frames);
        $display("Register writes: %0d, mismatches: %0d", cfg_writes, mism);
        if (mism == 0 && centroid_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== roi_motion_centroid_tracker_unit.f =====
+incdir+sv
sv/rmct_pkg.sv
sv/rmct_ctrl.sv
sv/rmct_datapath.sv
sv/roi_motion_centroid_tracker_unit.sv
verif/roi_motion_centroid_tracker_unit_tb.sv
